>>> rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg: shared constants for the pixel color postprocess block
// register indexes, reset values, field widths and fixed-point constants
// ----------------------------------------------------------------------------
package pcp_pkg;

   // default size limits for the image dimensions
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // field widths
   localparam int CH_W       = 16;   // q8.8 input channel, q0.16 output channel
   localparam int POS_W      = 12;   // column and row
   localparam int DIM_W      = 13;   // image width and height registers
   localparam int GAIN_W     = 16;   // q4.12 gains
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIM_EXT_W  = 15;   // holds any dimension limit up to 16384

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH       = 3'd0,
      CSR_IMAGE_HEIGHT      = 3'd1,
      CSR_CONTRAST_GAIN     = 3'd2,
      CSR_SATURATION_GAIN   = 3'd3,
      CSR_VIGNETTE_STRENGTH = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST       = 13'd640;
   localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST      = 13'd480;
   localparam logic [GAIN_W-1:0] CONTRAST_GAIN_RST     = 16'd4096;
   localparam logic [GAIN_W-1:0] SATURATION_GAIN_RST   = 16'd4096;
   localparam logic [GAIN_W-1:0] VIGNETTE_STRENGTH_RST = 16'd0;

   // fixed-point constants
   localparam int         FX_W     = 17;           // q0.16 value in [0, 1.0]
   localparam logic [16:0] Q16_ONE = 17'd65536;

   // normalized coordinate: quotient of (pos << 17) by (n - 1)
   localparam int AXIS_W = 29;

   // vignette distance square root
   localparam int SQ_W      = 59;   // sum of two squared offsets
   localparam int SQ_RAD_W  = 60;   // radicand padded to an even width
   localparam int SQ_ROOT_W = 30;
   localparam int SQ_REM_W  = 32;
   localparam int SQ_STEPS  = 30;

endpackage

>>> rtl/pcp_div.sv
// ----------------------------------------------------------------------------
// pcp_div: pipelined restoring divider
// one quotient bit per stage over several lanes sharing a valid and a tag;
// the numerator must be below den << QW
// ----------------------------------------------------------------------------
module pcp_div #(
   parameter int LANES = 1,
   parameter int NW    = 33,
   parameter int DW    = 17,
   parameter int QW    = 17,
   parameter int TW    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NW-1:0]    in_num,
   input  logic [LANES-1:0][DW-1:0]    in_den,
   input  logic [TW-1:0]               in_tag,
   output logic                        out_valid,
   output logic [LANES-1:0][QW-1:0]    out_quo,
   output logic [TW-1:0]               out_tag
);

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] quo;
   } step_type;

   logic                          valid_ff [QW];
   logic [TW-1:0]                 tag_ff   [QW];
   logic [LANES-1:0][DW-1:0]      den_ff   [QW];
   logic [LANES-1:0][QW-1:0]      num_ff   [QW];
   step_type [LANES-1:0]          step_ff  [QW];
   step_type [LANES-1:0]          step_in  [QW];

   function automatic step_type div_step(input logic [DW-1:0] rem,
                                         input logic          bit_in,
                                         input logic [DW-1:0] den,
                                         input logic [QW-1:0] quo);
      logic [DW:0] shifted;
      logic        fits;
      step_type    res;
      shifted = {rem, bit_in};
      fits    = shifted >= {1'b0, den};
      res.rem = fits ? DW'(shifted - {1'b0, den}) : shifted[DW-1:0];
      res.quo = QW'({quo, fits});
      return res;
   endfunction

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         step_in[0][l] = div_step(DW'(in_num[l] >> QW), in_num[l][QW-1], in_den[l], '0);
         for (int j = 1; j < QW; j++) begin
            step_in[j][l] = div_step(step_ff[j-1][l].rem, num_ff[j-1][l][QW-1-j],
                                     den_ff[j-1][l], step_ff[j-1][l].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QW; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j < QW; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         den_ff[0] <= in_den;
         for (int l = 0; l < LANES; l++) num_ff[0][l] <= in_num[l][QW-1:0];
         for (int j = 1; j < QW; j++) begin
            tag_ff[j] <= tag_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            num_ff[j] <= num_ff[j-1];
         end
         for (int j = 0; j < QW; j++) step_ff[j] <= step_in[j];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) out_quo[l] = step_ff[QW-1][l].quo;
   end

endmodule

>>> rtl/pixel_color_postprocess.sv
// ----------------------------------------------------------------------------
// pixel_color_postprocess: contrast, saturation, tone map and vignette
// finishes one linear rgb pixel per transfer, fully pipelined
// ----------------------------------------------------------------------------
//
//   channel | direction | payload
//   --------+-----------+-----------------------------------------------------
//   req     | in        | red_in, green_in, blue_in (q8.8), column, row
//   rsp     | out       | red_out, green_out, blue_out (q0.16)
//   csr     | in        | register index and write data, always ready
//
// one pixel per cycle sustained while rsp is ready; the depth of the path from req
// transfer to rsp valid is set mostly by the bit-per-stage dividers (29 stages
// for the coordinate, 17 for saturation, 16 for the tone map) and the 30
// stage square root of the vignette distance.
// synchronous active-high reset clears the valid bits and the configuration registers.
// a waiting rsp item freezes the whole pipeline, and req_tready drops with it.
//
module pixel_color_postprocess
   import pcp_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // pixel in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,   // red_in, green_in, blue_in, column, row
   // pixel out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata    // red_out, green_out, blue_out
);

   localparam int XDW = $clog2(MAX_WIDTH);
   localparam int YDW = $clog2(MAX_HEIGHT);
   localparam logic [DIM_EXT_W-1:0] MAXW = DIM_EXT_W'(MAX_WIDTH);
   localparam logic [DIM_EXT_W-1:0] MAXH = DIM_EXT_W'(MAX_HEIGHT);
   localparam int SAT_TAG_W = 3 * FX_W + 1 + 2 * FX_W;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_step_type;

   // configuration registers
   logic [DIM_W-1:0]  image_width_ff, image_height_ff;
   logic [GAIN_W-1:0] contrast_gain_ff, saturation_gain_ff, vignette_strength_ff;

   // global advance: everything moves unless a finished pixel waits
   logic en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff       <= IMAGE_WIDTH_RST;
         image_height_ff      <= IMAGE_HEIGHT_RST;
         contrast_gain_ff     <= CONTRAST_GAIN_RST;
         saturation_gain_ff   <= SATURATION_GAIN_RST;
         vignette_strength_ff <= VIGNETTE_STRENGTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:       image_width_ff       <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:      image_height_ff      <= csr_data[DIM_W-1:0];
            CSR_CONTRAST_GAIN:     contrast_gain_ff     <= csr_data;
            CSR_SATURATION_GAIN:   saturation_gain_ff   <= csr_data;
            CSR_VIGNETTE_STRENGTH: vignette_strength_ff <= csr_data;
            default: ;   // unknown index, write is dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // coordinate normalization: q = round((pos << 17) / (n - 1))
   // ---------------------------------------------------------------------
   logic [DIM_EXT_W-1:0] nx, ny, wx, wy;
   logic [XDW-1:0]       den_x;
   logic [YDW-1:0]       den_y;
   logic [AXIS_W-1:0]    num_x, num_y, qx, qy;
   logic                 ax_div_valid, ay_div_valid;
   logic [2*CH_W-1:0]    rg_tag;
   logic [CH_W-1:0]      b_tag;

   assign wx = DIM_EXT_W'(image_width_ff);
   assign wy = DIM_EXT_W'(image_height_ff);

   always_comb begin
      // sizes below two act as two, above the limit as the limit
      nx = (wx < DIM_EXT_W'(2)) ? DIM_EXT_W'(2) : ((wx > MAXW) ? MAXW : wx);
      ny = (wy < DIM_EXT_W'(2)) ? DIM_EXT_W'(2) : ((wy > MAXH) ? MAXH : wy);
      den_x = XDW'(nx - DIM_EXT_W'(1));
      den_y = YDW'(ny - DIM_EXT_W'(1));
      num_x = AXIS_W'({req_tdata[59:48], 17'b0}) + AXIS_W'(den_x >> 1);
      num_y = AXIS_W'({req_tdata[71:60], 17'b0}) + AXIS_W'(den_y >> 1);
   end

   assign req_tready = en;

   // x lane carries red and green along, y lane carries blue
   pcp_div #(.LANES(1), .NW(AXIS_W), .DW(XDW), .QW(AXIS_W), .TW(2*CH_W)) u_div_x (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_num(num_x), .in_den(den_x), .in_tag(req_tdata[31:0]),
      .out_valid(ax_div_valid), .out_quo(qx), .out_tag(rg_tag)
   );

   pcp_div #(.LANES(1), .NW(AXIS_W), .DW(YDW), .QW(AXIS_W), .TW(CH_W)) u_div_y (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_num(num_y), .in_den(den_y), .in_tag(req_tdata[47:32]),
      .out_valid(ay_div_valid), .out_quo(qy), .out_tag(b_tag)
   );

   // ---------------------------------------------------------------------
   // distance: offsets, squares, sum
   // ---------------------------------------------------------------------
   logic                 v1_valid_ff, v2_valid_ff, v3_valid_ff;
   logic [AXIS_W-1:0]    ax_ff, ay_ff;
   logic [2*AXIS_W-1:0]  sqx_ff, sqy_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [3*CH_W-1:0]    rgb_v1_ff, rgb_v2_ff, rgb_v3_ff;
   logic [AXIS_W-1:0]    ax_in, ay_in;
   localparam logic [AXIS_W-1:0] AXIS_ONE = AXIS_W'(65536);

   assign ax_in = (qx >= AXIS_ONE) ? qx - AXIS_ONE : AXIS_ONE - qx;
   assign ay_in = (qy >= AXIS_ONE) ? qy - AXIS_ONE : AXIS_ONE - qy;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         rgb_v1_ff <= {b_tag, rg_tag};
         sqx_ff    <= (2*AXIS_W)'(ax_ff) * (2*AXIS_W)'(ax_ff);
         sqy_ff    <= (2*AXIS_W)'(ay_ff) * (2*AXIS_W)'(ay_ff);
         rgb_v2_ff <= rgb_v1_ff;
         sq_ff     <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         rgb_v3_ff <= rgb_v2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // square root, two radicand bits per stage
   // ---------------------------------------------------------------------
   logic                 sq_valid_ff [SQ_STEPS];
   logic [3*CH_W-1:0]    sq_tag_ff   [SQ_STEPS];
   logic [SQ_RAD_W-1:0]  sq_rad_ff   [SQ_STEPS];
   sq_step_type          sq_step_ff  [SQ_STEPS];
   sq_step_type          sq_step_in  [SQ_STEPS];
   logic [SQ_RAD_W-1:0]  sq_rad;

   function automatic sq_step_type sqrt_step(input logic [SQ_REM_W-1:0]  rem,
                                             input logic [1:0]           pair,
                                             input logic [SQ_ROOT_W-1:0] root);
      logic [SQ_REM_W+1:0] cur;
      logic [SQ_REM_W+1:0] trial;
      logic                fits;
      sq_step_type         res;
      cur      = {rem, pair};
      trial    = (SQ_REM_W+2)'({root, 2'b01});
      fits     = cur >= trial;
      res.rem  = fits ? SQ_REM_W'(cur - trial) : SQ_REM_W'(cur);
      res.root = SQ_ROOT_W'({root, fits});
      return res;
   endfunction

   assign sq_rad = SQ_RAD_W'(sq_ff);

   always_comb begin
      sq_step_in[0] = sqrt_step('0, sq_rad[SQ_RAD_W-1 -: 2], '0);
      for (int j = 1; j < SQ_STEPS; j++) begin
         sq_step_in[j] = sqrt_step(sq_step_ff[j-1].rem, sq_rad_ff[j-1][SQ_RAD_W-1-2*j -: 2],
                                   sq_step_ff[j-1].root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQ_STEPS; j++) sq_valid_ff[j] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= v3_valid_ff;
         for (int j = 1; j < SQ_STEPS; j++) sq_valid_ff[j] <= sq_valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_tag_ff[0] <= rgb_v3_ff;
         sq_rad_ff[0] <= sq_rad;
         for (int j = 1; j < SQ_STEPS; j++) begin
            sq_tag_ff[j] <= sq_tag_ff[j-1];
            sq_rad_ff[j] <= sq_rad_ff[j-1];
         end
         for (int j = 0; j < SQ_STEPS; j++) sq_step_ff[j] <= sq_step_in[j];
      end
   end

   // ---------------------------------------------------------------------
   // rounded distance, falloff product
   // ---------------------------------------------------------------------
   logic                  v4_valid_ff, v5_valid_ff;
   logic [SQ_ROOT_W:0]    d_ff;
   logic [35:0]           p_ff;
   logic [3*CH_W-1:0]     rgb_v4_ff, rgb_v5_ff;
   sq_step_type           sq_last;

   assign sq_last = sq_step_ff[SQ_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         // round to nearest: bump when the remainder exceeds the root
         d_ff      <= (SQ_ROOT_W+1)'(sq_last.root)
                      + (SQ_ROOT_W+1)'(sq_last.rem > SQ_REM_W'(sq_last.root));
         rgb_v4_ff <= sq_tag_ff[SQ_STEPS-1];
         p_ff      <= 36'((48'(d_ff) * 48'(vignette_strength_ff) + 48'd2048) >> 12);
         rgb_v5_ff <= rgb_v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // contrast
   // ---------------------------------------------------------------------
   logic                     c1_valid_ff, c2_valid_ff, c3_valid_ff;
   logic [FX_W-1:0]          fac_in;
   logic [FX_W-1:0]          fac_c1_ff, fac_c2_ff, fac_c3_ff;
   logic signed [16:0]       cofs [3];
   logic signed [16:0]       cgain;
   logic signed [33:0]       cprod_ff [3];
   logic signed [34:0]       ct [3];
   logic [FX_W-1:0]          ch_in [3];
   logic [FX_W-1:0]          ch_c2_ff [3];
   logic [FX_W-1:0]          ch_c3_ff [3];
   logic [FX_W-1:0]          mx_in, mn_in, mx_ff, mn_ff;

   // factor is 1 - d * strength, floored at zero
   assign fac_in = (p_ff >= 36'd65536) ? '0 : FX_W'(36'd65536 - p_ff);
   assign cgain  = $signed({1'b0, contrast_gain_ff});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cofs[i] = $signed({1'b0, rgb_v5_ff[i*CH_W +: CH_W]}) - 17'sd128;
         ct[i]   = 35'(cprod_ff[i]) + 35'sd524288;
         if (ct[i] <= 35'sd0) begin
            ch_in[i] = '0;
         end else if (ct[i] >= 35'sd1048576) begin
            ch_in[i] = Q16_ONE;
         end else begin
            ch_in[i] = FX_W'((ct[i] + 35'sd8) >>> 4);
         end
      end
      mx_in = ch_c2_ff[0];
      mn_in = ch_c2_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (ch_c2_ff[i] > mx_in) mx_in = ch_c2_ff[i];
         if (ch_c2_ff[i] < mn_in) mn_in = ch_c2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cprod_ff[i] <= 34'(cofs[i]) * 34'(cgain);
            ch_c2_ff[i] <= ch_in[i];
            ch_c3_ff[i] <= ch_c2_ff[i];
         end
         fac_c1_ff <= fac_in;
         fac_c2_ff <= fac_c1_ff;
         fac_c3_ff <= fac_c2_ff;
         mx_ff     <= mx_in;
         mn_ff     <= mn_in;
      end
   end

   // ---------------------------------------------------------------------
   // hsl lightness and saturation ratio
   // ---------------------------------------------------------------------
   logic [FX_W:0]          hsl_sum;
   logic [FX_W-1:0]        light, sat_den, sat_diff;
   logic [32:0]            sat_num;
   logic [SAT_TAG_W-1:0]   sat_tag_in, sat_tag;
   logic [FX_W-1:0]        sat_ratio;
   logic                   sat_div_valid;

   always_comb begin
      hsl_sum  = (FX_W+1)'(mx_ff) + (FX_W+1)'(mn_ff);
      light    = FX_W'((hsl_sum + 18'd1) >> 1);
      // lightness below one half exactly when max + min is below one
      sat_den  = (hsl_sum < 18'd65536) ? FX_W'(hsl_sum) : FX_W'(18'd131072 - hsl_sum);
      sat_diff = mx_ff - mn_ff;
      sat_num  = {sat_diff, 16'b0} + 33'(sat_den >> 1);
      sat_tag_in = {fac_c3_ff, light, (mx_ff == mn_ff), ch_c3_ff[2], ch_c3_ff[1], ch_c3_ff[0]};
   end

   pcp_div #(.LANES(1), .NW(33), .DW(FX_W), .QW(FX_W), .TW(SAT_TAG_W)) u_div_sat (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c3_valid_ff), .in_num(sat_num), .in_den(sat_den), .in_tag(sat_tag_in),
      .out_valid(sat_div_valid), .out_quo(sat_ratio), .out_tag(sat_tag)
   );

   // ---------------------------------------------------------------------
   // saturation gain and blend
   // ---------------------------------------------------------------------
   logic                   c4_valid_ff, c5_valid_ff, c6_valid_ff, c7_valid_ff;
   logic [33:0]            gprod_ff;
   logic [SAT_TAG_W-1:0]   tag_c4_ff;
   logic [21:0]            gval;
   logic [FX_W-1:0]        s_in, s_ff, oms_ff, l_c5_ff;
   logic [FX_W-1:0]        ch_c5_ff [3];
   logic [FX_W-1:0]        fac_c5_ff, fac_c6_ff, fac_c7_ff;
   logic [33:0]            lp_ff;
   logic [33:0]            cp_ff [3];
   logic [FX_W-1:0]        b_ff [3];

   assign gval = 22'(gprod_ff >> 12);
   // a gray pixel has no saturation
   assign s_in = tag_c4_ff[3*FX_W] ? '0
               : ((gval > 22'(Q16_ONE)) ? Q16_ONE : FX_W'(gval));

   always_ff @(posedge clock) begin
      if (en) begin
         gprod_ff  <= 34'(sat_ratio) * 34'(saturation_gain_ff) + 34'd2048;
         tag_c4_ff <= sat_tag;
         s_ff      <= s_in;
         oms_ff    <= Q16_ONE - s_in;
         l_c5_ff   <= tag_c4_ff[3*FX_W+1 +: FX_W];
         fac_c5_ff <= tag_c4_ff[4*FX_W+1 +: FX_W];
         for (int i = 0; i < 3; i++) ch_c5_ff[i] <= tag_c4_ff[i*FX_W +: FX_W];
         lp_ff     <= 34'(l_c5_ff) * 34'(oms_ff);
         for (int i = 0; i < 3; i++) cp_ff[i] <= 34'(ch_c5_ff[i]) * 34'(s_ff);
         fac_c6_ff <= fac_c5_ff;
         for (int i = 0; i < 3; i++) begin
            b_ff[i] <= FX_W'((35'(lp_ff) + 35'(cp_ff[i]) + 35'd32768) >> 16);
         end
         fac_c7_ff <= fac_c6_ff;
      end
   end

   // ---------------------------------------------------------------------
   // tone map x / (1 + x), then vignette factor
   // ---------------------------------------------------------------------
   logic [2:0][17:0]     tone_den;
   logic [2:0][32:0]     tone_num;
   logic [2:0][15:0]     tone_q;
   logic [FX_W-1:0]      tone_fac;
   logic                 tone_valid;
   logic                 c8_valid_ff;
   logic [32:0]          op_ff [3];
   logic                 rsp_tvalid_ff;
   logic [CH_W-1:0]      rsp_ch_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tone_den[i] = 18'd65536 + 18'(b_ff[i]);
         tone_num[i] = {b_ff[i], 16'b0} + 33'(tone_den[i] >> 1);
      end
   end

   pcp_div #(.LANES(3), .NW(33), .DW(18), .QW(16), .TW(FX_W)) u_div_tone (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c7_valid_ff), .in_num(tone_num), .in_den(tone_den), .in_tag(fac_c7_ff),
      .out_valid(tone_valid), .out_quo(tone_q), .out_tag(tone_fac)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            op_ff[i]     <= 33'(tone_q[i]) * 33'(tone_fac);
            rsp_ch_ff[i] <= CH_W'((op_ff[i] + 33'd32768) >> 16);
         end
      end
   end

   // valid bits of the stages outside the dividers and the square root
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_valid_ff   <= 1'b0;
         v2_valid_ff   <= 1'b0;
         v3_valid_ff   <= 1'b0;
         v4_valid_ff   <= 1'b0;
         v5_valid_ff   <= 1'b0;
         c1_valid_ff   <= 1'b0;
         c2_valid_ff   <= 1'b0;
         c3_valid_ff   <= 1'b0;
         c4_valid_ff   <= 1'b0;
         c5_valid_ff   <= 1'b0;
         c6_valid_ff   <= 1'b0;
         c7_valid_ff   <= 1'b0;
         c8_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         v1_valid_ff   <= ax_div_valid;
         v2_valid_ff   <= v1_valid_ff;
         v3_valid_ff   <= v2_valid_ff;
         v4_valid_ff   <= sq_valid_ff[SQ_STEPS-1];
         v5_valid_ff   <= v4_valid_ff;
         c1_valid_ff   <= v5_valid_ff;
         c2_valid_ff   <= c1_valid_ff;
         c3_valid_ff   <= c2_valid_ff;
         c4_valid_ff   <= sat_div_valid;
         c5_valid_ff   <= c4_valid_ff;
         c6_valid_ff   <= c5_valid_ff;
         c7_valid_ff   <= c6_valid_ff;
         c8_valid_ff   <= tone_valid;
         rsp_tvalid_ff <= c8_valid_ff;
      end
   end

   // the output register is free once its pixel is taken
   assign en         = rsp_tready || !rsp_tvalid_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ch_ff[2], rsp_ch_ff[1], rsp_ch_ff[0]};

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // both coordinate dividers must stay in lockstep
   a_axis_lockstep: assert property (@(posedge clock) disable iff (reset)
      ax_div_valid == ay_div_valid)
      else $error("coordinate divider lanes out of step");

   // tone map halves the range, so no channel exceeds one half
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] <= 16'h8000 && rsp_tdata[31:16] <= 16'h8000
                      && rsp_tdata[47:32] <= 16'h8000))
      else $error("output channel above one half");

   // scaled saturation is clamped to one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      c5_valid_ff |-> (s_ff <= Q16_ONE && oms_ff == Q16_ONE - s_ff))
      else $error("saturation out of range");

   // an empty output register never blocks the input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule
